FILE: src/bmpdec_pkg.sv
// Shared types and constants for the bitmap stream pixel decoder.
`default_nettype none
package bmpdec_pkg;
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXELS = 3'd2,
    PH_DONE   = 3'd3,
    PH_IDLE   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    REP_PIXEL  = 2'd0,
    REP_IMAGE  = 2'd1,
    REP_SCREEN = 2'd2,
    REP_DONE   = 2'd3
  } report_e;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_DISP_W   = 3'd2;
  localparam logic [2:0] CFG_DISP_H   = 3'd3;
  localparam logic [2:0] CFG_DEPTH    = 3'd4;

  localparam logic [1:0] DEPTH_COLOR = 2'd0;
  localparam logic [1:0] DEPTH_MONO  = 2'd1;

  localparam int unsigned HDR_LAST    = 29;
  localparam int unsigned HDR_LEN     = 30;
  localparam logic [9:0]  MONO3_LIMIT = 10'd381;
  localparam logic [4:0]  MONO2_LIMIT = 5'd10;

  typedef struct packed {
    logic        emit;
    report_e     kind;
    logic        is_mono;
    logic        two_byte;
    logic [23:0] bytes;
    logic [13:0] x;
    logic [13:0] y;
  } job_t;
endpackage
`default_nettype wire

FILE: src/bmpdec_front.sv
// Front end: header parse, byte skip, pixel assembly and coordinate generation.
`default_nettype none
module bmpdec_front #(
  parameter int unsigned MaxImageDim = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          file_byte_i,
  input  wire logic                start_flag_i,
  input  wire logic signed [12:0]  origin_x_i,
  input  wire logic signed [12:0]  origin_y_i,
  input  wire logic [1:0]          depth_i,
  input  wire logic                q_full_i,
  output logic                     job_valid_o,
  output bmpdec_pkg::job_t         job_o
);
  bmpdec_pkg::phase_e phase_q, phase_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [31:0] hw_q, hw_d, hh_q, hh_d;
  logic [15:0] bits_q, bits_d;
  logic [7:0]  off_q, off_d;
  logic [12:0] iw_q, iw_d, ih_q, ih_d, row_q, row_d, col_q, col_d;
  logic        td_q, td_d;
  logic [2:0]  bpp_q, bpp_d;
  logic [23:0] pb_q, pb_d;
  logic [1:0]  pi_q, pi_d;

  logic        acc;
  logic [15:0] bits_full;
  logic [12:0] bpp_w;
  logic [31:0] hh_full, hmag;
  logic [12:0] rowpos;
  logic [23:0] pb_full;
  logic [1:0]  byte_sel;

  assign in_stall_o = q_full_i;
  assign acc = in_valid_i && !q_full_i;

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; hw_d = hw_q; hh_d = hh_q; bits_d = bits_q;
    off_d = off_q; iw_d = iw_q; ih_d = ih_q; row_d = row_q; col_d = col_q;
    td_d = td_q; bpp_d = bpp_q; pb_d = pb_q; pi_d = pi_q;
    job_valid_o = 1'b0;
    job_o = '0;
    job_o.kind = bmpdec_pkg::REP_PIXEL;
    bits_full = bits_q; hh_full = hh_q; hmag = '0; bpp_w = '0;
    rowpos = '0; pb_full = pb_q;
    byte_sel = '0;
    if (acc) begin
      if (start_flag_i || phase_q != bmpdec_pkg::PH_DONE) begin
        if (start_flag_i) begin
          if (phase_q == bmpdec_pkg::PH_DONE) begin
            job_valid_o = 1'b1;
            job_o.kind = bmpdec_pkg::REP_DONE;
          end
          phase_d = bmpdec_pkg::PH_HEADER; cnt_d = '0; hw_d = '0; hh_d = '0;
          bits_d = '0; off_d = '0;
        end
        case (start_flag_i ? bmpdec_pkg::PH_HEADER : phase_q)
          bmpdec_pkg::PH_HEADER: begin
            if (start_flag_i) begin
              hw_d = '0; hh_d = '0; bits_d = '0;
            end
            byte_sel = cnt_d[1:0] + 2'd2;
            if (cnt_d == 8'd10) off_d = file_byte_i;
            if (cnt_d inside {[8'd18:8'd21]})
              hw_d[8*byte_sel+:8] = file_byte_i;
            if (cnt_d inside {[8'd22:8'd25]})
              hh_d[8*byte_sel+:8] = file_byte_i;
            if (cnt_d == 8'd28) bits_d[7:0] = file_byte_i;
            if (cnt_d == 8'd29) bits_d[15:8] = file_byte_i;
            bits_full = bits_d; hh_full = hh_d;
            if (cnt_d != 8'(bmpdec_pkg::HDR_LAST)) begin
              cnt_d = cnt_d + 8'd1;
            end else begin
              bpp_w = bits_full[15:3];
              hmag = hh_full[31] ? (~hh_full + 32'd1) : hh_full;
              if (bpp_w < 13'd2 || bpp_w > 13'd4 || hw_d > 32'(MaxImageDim) ||
                  hmag > 32'(MaxImageDim)) begin
                job_valid_o = 1'b1;
                job_o.kind = bmpdec_pkg::REP_IMAGE;
                phase_d = bmpdec_pkg::PH_IDLE;
              end else if (depth_i > bmpdec_pkg::DEPTH_MONO) begin
                job_valid_o = 1'b1;
                job_o.kind = bmpdec_pkg::REP_SCREEN;
                phase_d = bmpdec_pkg::PH_IDLE;
              end else begin
                iw_d = hw_d[12:0]; ih_d = hmag[12:0]; td_d = hh_full[31];
                bpp_d = bpp_w[2:0];
                if (off_d <= 8'(bmpdec_pkg::HDR_LEN)) begin
                  row_d = '0; col_d = '0; pb_d = '0; pi_d = '0;
                  phase_d = (iw_d == '0 || ih_d == '0) ? bmpdec_pkg::PH_DONE
                                                       : bmpdec_pkg::PH_PIXELS;
                end else begin
                  phase_d = bmpdec_pkg::PH_SKIP;
                  cnt_d = 8'(bmpdec_pkg::HDR_LEN);
                end
              end
            end
          end
          bmpdec_pkg::PH_SKIP: begin
            if ({1'b0, cnt_q} + 9'd1 >= {1'b0, off_q}) begin
              row_d = '0; col_d = '0; pb_d = '0; pi_d = '0;
              phase_d = (iw_q == '0 || ih_q == '0) ? bmpdec_pkg::PH_DONE
                                                   : bmpdec_pkg::PH_PIXELS;
            end else begin
              cnt_d = cnt_q + 8'd1;
            end
          end
          bmpdec_pkg::PH_PIXELS: begin
            if (pi_q != 2'd3) pb_full[8*pi_q+:8] = file_byte_i;
            if ({1'b0, pi_q} + 3'd1 < bpp_q) begin
              pb_d = pb_full;
              pi_d = pi_q + 2'd1;
            end else begin
              rowpos = td_q ? row_q : (ih_q - 13'd1 - row_q);
              job_valid_o = 1'b1;
              job_o.emit = 1'b1;
              job_o.is_mono = (depth_i == bmpdec_pkg::DEPTH_MONO);
              job_o.two_byte = (bpp_q == 3'd2);
              job_o.bytes = pb_full;
              job_o.x = {origin_x_i[12], origin_x_i} + {1'b0, col_q};
              job_o.y = {origin_y_i[12], origin_y_i} + {1'b0, rowpos};
              pb_d = '0; pi_d = '0;
              if (col_q + 13'd1 >= iw_q) begin
                col_d = '0;
                row_d = row_q + 13'd1;
                if (row_q + 13'd1 >= ih_q) phase_d = bmpdec_pkg::PH_DONE;
              end else begin
                col_d = col_q + 13'd1;
              end
            end
          end
          default: ;
        endcase
      end else begin
        job_valid_o = 1'b1;
        job_o.kind = bmpdec_pkg::REP_DONE;
        phase_d = bmpdec_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bmpdec_pkg::PH_HEADER;
      cnt_q <= '0; hw_q <= '0; hh_q <= '0; bits_q <= '0; off_q <= '0;
      iw_q <= '0; ih_q <= '0; row_q <= '0; col_q <= '0; td_q <= 1'b0;
      bpp_q <= '0; pb_q <= '0; pi_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q <= cnt_d; hw_q <= hw_d; hh_q <= hh_d; bits_q <= bits_d; off_q <= off_d;
      iw_q <= iw_d; ih_q <= ih_d; row_q <= row_d; col_q <= col_d; td_q <= td_d;
      bpp_q <= bpp_d; pb_q <= pb_d; pi_q <= pi_d;
    end
  end
endmodule
`default_nettype wire

FILE: src/bmpdec_fifo.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module bmpdec_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire bmpdec_pkg::job_t push_data_i,
  output logic                  full_o,
  output logic                  pop_valid_o,
  output bmpdec_pkg::job_t      pop_data_o,
  input  wire logic             pop_i
);
  bmpdec_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

FILE: src/bmpdec_back.sv
// Back end: clipping, color conversion and the output register.
`default_nettype none
module bmpdec_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  wire bmpdec_pkg::job_t job_i,
  output logic                  job_pop_o,
  input  wire logic [12:0]      disp_w_i,
  input  wire logic [12:0]      disp_h_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [11:0]           pixel_x_o,
  output logic [11:0]           pixel_y_o,
  output logic [15:0]           pixel_color_o,
  output logic [1:0]            report_kind_o
);
  logic [12:0] dw, dh;
  logic        visible, take, load;
  logic [7:0]  b0, b1, b2;
  logic [15:0] color;
  logic [4:0]  s2;
  logic [9:0]  s3;

  assign dw = (disp_w_i > 13'd4096) ? 13'd4096 : disp_w_i;
  assign dh = (disp_h_i > 13'd4096) ? 13'd4096 : disp_h_i;
  assign b0 = job_i.bytes[7:0];
  assign b1 = job_i.bytes[15:8];
  assign b2 = job_i.bytes[23:16];
  assign s2 = 5'(b1[7:5]) + 5'(b1[2:0]) + 5'(b0[4:2]);
  assign s3 = 10'(b0) + 10'(b1) + 10'(b2);
  assign visible = !job_i.emit ||
                   (!job_i.x[13] && job_i.x[12:0] < dw && !job_i.y[13] && job_i.y[12:0] < dh);

  always_comb begin
    color = '0;
    if (job_i.emit) begin
      if (job_i.two_byte) begin
        color = job_i.is_mono ? 16'(s2 > bmpdec_pkg::MONO2_LIMIT) : {b1, b0};
      end else begin
        color = job_i.is_mono ? 16'(s3 > bmpdec_pkg::MONO3_LIMIT)
                              : {b2[7:3], b1[7:2], b0[7:3]};
      end
    end
  end

  assign take = !out_valid_o || !out_stall_i;
  assign job_pop_o = job_valid_i && take;
  assign load = job_pop_o && visible;

  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_x_o     <= job_i.x[11:0];
      pixel_y_o     <= job_i.y[11:0];
      pixel_color_o <= color;
      report_kind_o <= job_i.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (take) begin
      out_valid_o <= load;
    end
  end
endmodule
`default_nettype wire

FILE: src/bmp_stream_pixel_decoder.sv
// Top level of the bitmap stream pixel decoder.
`default_nettype none
// Takes one file byte per clock: a front end parses the header and assembles pixels,
// a two-entry queue decouples it from a back end that clips, converts to RGB565 or
// mono and holds the result beat in an output register. Sustained rate is one byte
// per cycle; input stalls only while the queue is full because the output is stalled.
// A result beat is held in a queue entry and then in the output register. No clearing
// pass after reset.
module bmp_stream_pixel_decoder #(
  parameter int unsigned MaxImageDim = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  file_byte_i,
  input  wire logic        start_flag_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      pixel_x_o,
  output logic [11:0]      pixel_y_o,
  output logic [15:0]      pixel_color_o,
  output logic [1:0]       report_kind_o
);
  logic signed [12:0] ox_q, oy_q;
  logic [12:0] dw_q, dh_q;
  logic [1:0]  dep_q;
  logic        full, jv, pv, pop;
  bmpdec_pkg::job_t job, pjob;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0; oy_q <= '0; dw_q <= 13'd128; dh_q <= 13'd64;
      dep_q <= bmpdec_pkg::DEPTH_COLOR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bmpdec_pkg::CFG_ORIGIN_X: ox_q <= cfg_data_i;
        bmpdec_pkg::CFG_ORIGIN_Y: oy_q <= cfg_data_i;
        bmpdec_pkg::CFG_DISP_W:   dw_q <= cfg_data_i;
        bmpdec_pkg::CFG_DISP_H:   dh_q <= cfg_data_i;
        bmpdec_pkg::CFG_DEPTH:    dep_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  bmpdec_front #(.MaxImageDim(MaxImageDim)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .file_byte_i, .start_flag_i,
    .origin_x_i(ox_q), .origin_y_i(oy_q), .depth_i(dep_q), .q_full_i(full),
    .job_valid_o(jv), .job_o(job)
  );

  bmpdec_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(jv), .push_data_i(job), .full_o(full),
    .pop_valid_o(pv), .pop_data_o(pjob), .pop_i(pop)
  );

  bmpdec_back u_back (
    .clk_i, .rst_ni, .job_valid_i(pv), .job_i(pjob), .job_pop_o(pop),
    .disp_w_i(dw_q), .disp_h_i(dh_q), .out_valid_o, .out_stall_i,
    .pixel_x_o, .pixel_y_o, .pixel_color_o, .report_kind_o
  );
endmodule
`default_nettype wire

FILE: src/bmpdec_checker.sv
// Port-level checker for the bitmap stream pixel decoder.
`default_nettype none
module bmpdec_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [11:0] pixel_x_o,
  input wire logic [15:0] pixel_color_o,
  input wire logic [1:0]  report_kind_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_color_o))
    else $error("output beat dropped while stalled");
  a_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_kind_o != 2'd0 |-> pixel_x_o == '0 && pixel_color_o == '0)
    else $error("report beat carries nonzero fields");
  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stalled with idle output");
endmodule

bind bmp_stream_pixel_decoder bmpdec_checker u_bmpdec_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .pixel_x_o, .pixel_color_o, .report_kind_o
);
`default_nettype wire

FILE: tb/bmp_stream_pixel_decoder_tb.sv
// Self-checking testbench for the bitmap stream pixel decoder.
`timescale 1ns / 100ps
`default_nettype none
module bmp_stream_pixel_decoder_tb;
  localparam int unsigned MaxDim = 4096;

  typedef struct packed {
    logic [11:0]         x;
    logic [11:0]         y;
    logic [15:0]         color;
    bmpdec_pkg::report_e kind;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  file_byte_i = '0;
  logic        start_flag_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [11:0] pixel_x_o;
  logic [11:0] pixel_y_o;
  logic [15:0] pixel_color_o;
  logic [1:0]  report_kind_o;

  bmp_stream_pixel_decoder u_top (.*);

  always #5 clk_i = ~clk_i;

  // decoder shadow state
  logic signed [12:0] org_x, org_y;
  logic [12:0] disp_w, disp_h;
  logic [1:0]  depth;
  bmpdec_pkg::phase_e phase;
  int unsigned byte_cnt, hdr_w, hdr_h, hdr_bits, img_w, img_h, bpp, data_off;
  int unsigned row_cnt, col_cnt, pix_bytes, pix_idx;
  bit          top_down;

  pixel_t      expected_pixels[$];
  int          errors = 0;
  longint      cycles = 0;
  bit          out_busy = 1'b0;
  int          bytes_sent = 0;

  task automatic queue_pixel(int x, int y, int c, bmpdec_pkg::report_e k);
    pixel_t p;
    p.x = x[11:0];
    p.y = y[11:0];
    p.color = c[15:0];
    p.kind = k;
    expected_pixels.push_back(p);
  endtask

  task automatic restart_parse();
    phase = bmpdec_pkg::PH_HEADER;
    byte_cnt = 0;
    hdr_w = 0;
    hdr_h = 0;
    hdr_bits = 0;
    data_off = 0;
  endtask

  task automatic begin_pixels();
    row_cnt = 0;
    col_cnt = 0;
    pix_bytes = 0;
    pix_idx = 0;
    phase = (img_w == 0 || img_h == 0) ? bmpdec_pkg::PH_DONE : bmpdec_pkg::PH_PIXELS;
  endtask

  task automatic predict_byte(logic [7:0] b, logic st);
    int unsigned i, mag, b0, b1, b2, c, dw, dh;
    int          row, x0, y0;
    bit          neg;
    if (st) begin
      if (phase == bmpdec_pkg::PH_DONE) queue_pixel(0, 0, 0, bmpdec_pkg::REP_DONE);
      restart_parse();
    end else if (phase == bmpdec_pkg::PH_DONE) begin
      queue_pixel(0, 0, 0, bmpdec_pkg::REP_DONE);
      phase = bmpdec_pkg::PH_IDLE;
      return;
    end
    case (phase)
      bmpdec_pkg::PH_HEADER: begin
        i = byte_cnt;
        if (i == 10) data_off = b;
        if (i >= 18 && i <= 21) hdr_w |= b << (8 * (i - 18));
        if (i >= 22 && i <= 25) hdr_h |= b << (8 * (i - 22));
        if (i == 28) hdr_bits |= b;
        if (i == bmpdec_pkg::HDR_LAST) hdr_bits |= b << 8;
        if (i != bmpdec_pkg::HDR_LAST) begin
          byte_cnt = i + 1;
        end else begin
          neg = hdr_h[31];
          mag = neg ? (~hdr_h + 1) : hdr_h;
          if ((hdr_bits >> 3) < 2 || (hdr_bits >> 3) > 4 || hdr_w > MaxDim || mag > MaxDim) begin
            queue_pixel(0, 0, 0, bmpdec_pkg::REP_IMAGE);
            phase = bmpdec_pkg::PH_IDLE;
          end else if (depth > 1) begin
            queue_pixel(0, 0, 0, bmpdec_pkg::REP_SCREEN);
            phase = bmpdec_pkg::PH_IDLE;
          end else begin
            img_w = hdr_w;
            img_h = mag;
            top_down = neg;
            bpp = hdr_bits >> 3;
            if (data_off <= bmpdec_pkg::HDR_LEN) begin_pixels();
            else begin
              phase = bmpdec_pkg::PH_SKIP;
              byte_cnt = bmpdec_pkg::HDR_LEN;
            end
          end
        end
      end
      bmpdec_pkg::PH_SKIP: begin
        if (byte_cnt + 1 >= data_off) begin_pixels();
        else byte_cnt = (byte_cnt + 1) & 8'hff;
      end
      bmpdec_pkg::PH_PIXELS: begin
        if (pix_idx < 3) pix_bytes |= b << (8 * pix_idx);
        if (pix_idx + 1 < bpp) begin
          pix_idx = (pix_idx + 1) & 3;
        end else begin
          b0 = pix_bytes & 8'hff;
          b1 = (pix_bytes >> 8) & 8'hff;
          b2 = (pix_bytes >> 16) & 8'hff;
          dw = disp_w > MaxDim ? MaxDim : disp_w;
          dh = disp_h > MaxDim ? MaxDim : disp_h;
          row = top_down ? int'(row_cnt) : int'(img_h) - 1 - int'(row_cnt);
          x0 = int'(org_x) + int'(col_cnt);
          y0 = int'(org_y) + row;
          if (x0 >= 0 && x0 < int'(dw) && y0 >= 0 && y0 < int'(dh)) begin
            if (bpp == 2) begin
              if (depth == bmpdec_pkg::DEPTH_MONO)
                c = ((b1 >> 5) + (b1 & 7) + ((b0 >> 2) & 7)) > bmpdec_pkg::MONO2_LIMIT ? 1 : 0;
              else c = (b1 << 8) | b0;
            end else begin
              if (depth == bmpdec_pkg::DEPTH_MONO)
                c = (b0 + b1 + b2) > bmpdec_pkg::MONO3_LIMIT ? 1 : 0;
              else c = ((b2 >> 3) << 11) | ((b1 >> 2) << 5) | (b0 >> 3);
            end
            queue_pixel(x0, y0, c, bmpdec_pkg::REP_PIXEL);
          end
          pix_idx = 0;
          pix_bytes = 0;
          col_cnt++;
          if (col_cnt >= img_w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= img_h) phase = bmpdec_pkg::PH_DONE;
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic send_byte(logic [7:0] b, logic st);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    file_byte_i <= b;
    start_flag_i <= st;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b, st);
    bytes_sent++;
  endtask

  // header, filler bytes up to the data offset, plus pixel body
  task automatic send_image(int w, int h, int bits, int off, bit random_body);
    logic [7:0] hb[30];
    int hv, n, mag, bytes_pp;
    hv = h;
    foreach (hb[k]) hb[k] = random_body ? 8'($urandom) : 8'h00;
    hb[0] = 8'h42;
    hb[1] = 8'h4d;
    hb[10] = off[7:0];
    {hb[21], hb[20], hb[19], hb[18]} = w;
    {hb[25], hb[24], hb[23], hb[22]} = hv;
    {hb[29], hb[28]} = bits[15:0];
    for (int k = 0; k < 30; k++) send_byte(hb[k], k == 0);
    for (int k = 30; k < off; k++) send_byte(8'($urandom), 1'b0);
    mag = h < 0 ? -h : h;
    bytes_pp = bits >> 3;
    if (bytes_pp >= 2 && bytes_pp <= 4 && w <= MaxDim && mag <= MaxDim)
      n = w * mag * bytes_pp;
    else
      n = 3;
    for (int k = 0; k < n; k++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0 || out_busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bmpdec_pkg::CFG_ORIGIN_X: org_x = val;
      bmpdec_pkg::CFG_ORIGIN_Y: org_y = val;
      bmpdec_pkg::CFG_DISP_W:   disp_w = val;
      bmpdec_pkg::CFG_DISP_H:   disp_h = val;
      bmpdec_pkg::CFG_DEPTH:    depth = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_screen(int ox, int oy, int dw, int dh, int dep);
    drain();
    write_reg(bmpdec_pkg::CFG_ORIGIN_X, ox[12:0]);
    write_reg(bmpdec_pkg::CFG_ORIGIN_Y, oy[12:0]);
    write_reg(bmpdec_pkg::CFG_DISP_W, dw[12:0]);
    write_reg(bmpdec_pkg::CFG_DISP_H, dh[12:0]);
    write_reg(bmpdec_pkg::CFG_DEPTH, dep[12:0]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    set_screen(0, 0, 128, 64, bmpdec_pkg::DEPTH_COLOR);
    send_image(3, 2, 24, 54, 1'b1);
    send_image(2, -2, 16, 20, 1'b1);
    send_byte(8'hff, 1'b0);
    send_image(1, 1, 32, 30, 1'b0);
    send_image(0, 3, 24, 30, 1'b0);
    send_image(2, 2, 8, 30, 1'b0);
    send_image(4097, 1, 24, 30, 1'b0);
    send_image(1, -4097, 24, 30, 1'b0);
    send_image(4, 1, 24, 30, 1'b1);
    send_image(2, 1, 16, 30, 1'b1);
    set_screen(-1, -1, 2, 1, bmpdec_pkg::DEPTH_MONO);
    send_image(3, 2, 24, 30, 1'b0);
    send_image(3, 2, 16, 30, 1'b0);
    set_screen(4095, 0, 4096, 4096, 2);
    send_image(1, 1, 24, 30, 1'b0);
    set_screen(-4096, 4095, 8191, 1, 3);
    send_image(1, 1, 24, 30, 1'b0);
  endtask

  task automatic test_random(int items);
    int stop, w, h, bits, off, r;
    stop = bytes_sent + items;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 9) == 0)
        set_screen($urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6,
                   $urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_byte(8'($urandom), 1'($urandom));
      end else begin
        w = $urandom_range(0, 6);
        h = $urandom_range(0, 5);
        if ($urandom_range(0, 1)) h = -h;
        bits = 8 * $urandom_range(2, 4);
        if (r < 12) bits = $urandom_range(0, 65535);
        off = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : 30;
        send_image(w, h, bits, off, 1'b1);
      end
    end
  endtask

  task automatic test_pause();
    send_image(3, 3, 24, 30, 1'b1);
    drain();
    send_image(2, 2, 16, 34, 1'b1);
    send_byte(8'h00, 1'b0);
  endtask

  // result checker and stall generator
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t unexpected beat: x=%0d y=%0d c=%h k=%0d", $time,
                   pixel_x_o, pixel_y_o, pixel_color_o, report_kind_o);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_x_o !== want.x || pixel_y_o !== want.y ||
              pixel_color_o !== want.color || report_kind_o !== want.kind) begin
            $display("%0t mismatch: expected x=%0d y=%0d c=%h k=%0d, actual x=%0d y=%0d c=%h k=%0d",
                     $time, want.x, want.y, want.color, want.kind,
                     pixel_x_o, pixel_y_o, pixel_color_o, report_kind_o);
            errors++;
          end
        end
      end
      out_busy <= out_valid_o;
      out_stall_i <= (cycles % 700 < 200) ? 1'b0 : ($urandom_range(0, 99) < 30);
      if (cycles > 2_000_000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    org_x = 0;
    org_y = 0;
    disp_w = 128;
    disp_h = 64;
    depth = bmpdec_pkg::DEPTH_COLOR;
    restart_parse();
    img_w = 0;
    img_h = 0;
    bpp = 0;
    top_down = 0;
    row_cnt = 0;
    col_cnt = 0;
    pix_bytes = 0;
    pix_idx = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pause();
    test_random(150);
    drain();
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
